// File: rtl/ddc_pkg.sv
// Shared types, constants and the control program of the dependency delay closure block.
package ddc_pkg;

    // Default node count.
    localparam int NODES_DEF = 26;

    // Widths of the item fields.
    localparam int OP_W    = 2;
    localparam int NODE_W  = 5;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_EDGE    = 2'd0,
        OP_MARK    = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Program steps; the step counter holds one of these.
    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_PASS  = 2'd1,
        ST_SCAN  = 2'd2,
        ST_CLEAR = 2'd3
    } t_step;

    // Datapath action selected by a control word.
    typedef enum logic [1:0] {
        A_LOAD  = 2'd0,
        A_PASS  = 2'd1,
        A_SCAN  = 2'd2,
        A_CLEAR = 2'd3
    } t_act;

    // Jump condition; when it fails the sequencer stays on its step.
    typedef enum logic [1:0] {
        C_ALWAYS  = 2'd0,
        C_COMPUTE = 2'd1,
        C_STABLE  = 2'd2,
        C_EMPTY   = 2'd3
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    // Control store: one word per step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            ST_WAIT:  w = '{in_ready: 1'b1, act: A_LOAD,  cond: C_COMPUTE, target: ST_PASS};
            ST_PASS:  w = '{in_ready: 1'b0, act: A_PASS,  cond: C_STABLE,  target: ST_SCAN};
            ST_SCAN:  w = '{in_ready: 1'b0, act: A_SCAN,  cond: C_EMPTY,   target: ST_CLEAR};
            ST_CLEAR: w = '{in_ready: 1'b0, act: A_CLEAR, cond: C_ALWAYS,  target: ST_WAIT};
            default:  w = '{in_ready: 1'b0, act: A_CLEAR, cond: C_ALWAYS,  target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/dependency_delay_closure.sv
// Top level of the dependency delay closure block: microcoded sequencer and its datapath.
//
// Usage: items arrive on the slave channel (i_s_tvalid, o_s_tready, i_s_tdata).
// An add-edge item records that one node depends on another, a mark item sets a
// node in the delayed set, and a compute item starts the closure. Load items
// are accepted without stall on the wait step. A compute item runs the spreading
// pass once per cycle until the delayed set stops growing (at most NODES passes,
// set by the depth of the longest dependency chain), then scans the nodes one per
// cycle, unless stalled by the output register, in ascending order up to the
// highest delayed node, plus a step that finds none left, and emits each delayed
// node on the master channel (o_m_tvalid, i_m_tready, o_m_tdata, o_m_tlast) with
// tlast on the final one. A clear step then wipes all edges and marks.
// Results pass through a single output register: while it holds an item the
// receiver has not taken, the scan stalls on delayed nodes and resumes when
// the item is taken. The slave channel is ready only on the wait step, which
// is also reached while a last result still sits in the output register.
// Reset (synchronous, active low) clears the edges, the delayed set, the step
// counter and the output valid flag; an item still held in the output register
// is dropped.
module dependency_delay_closure #(
    parameter int NODES = ddc_pkg::NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0 up: operation[1:0], project[6:2], depends_on[11:7], zeros.
    input  logic [ddc_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // Fields from bit 0 up: delayed_node[4:0], zeros.
    output logic [ddc_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int IDX_W = $clog2(NODES);

    // Edge rows: bit d of row p is set when node p depends on node d.
    logic [NODES-1:0] r_rows [NODES];
    // Delayed set; during the pass step it grows in place to its closure.
    logic [NODES-1:0] r_mask;
    // Nodes still to emit, shifted right each time the scan advances.
    logic [NODES-1:0] r_rem;
    logic [IDX_W-1:0] r_idx;

    ddc_pkg::t_step   r_step;
    ddc_pkg::t_step   n_step;
    ddc_pkg::t_uword  uw;

    logic                       r_m_tvalid;
    logic [ddc_pkg::NODE_W-1:0] r_m_node;
    logic                       r_m_last;

    ddc_pkg::t_op               in_op;
    logic [ddc_pkg::NODE_W-1:0] in_proj;
    logic [ddc_pkg::NODE_W-1:0] in_dep;
    logic                       in_accept;
    logic                       proj_ok;
    logic                       dep_ok;

    logic [NODES-1:0] spread;
    logic             cond_met;
    logic             scan_adv;

    assign in_op   = ddc_pkg::t_op'(i_s_tdata[ddc_pkg::OP_W-1:0]);
    assign in_proj = i_s_tdata[ddc_pkg::OP_W +: ddc_pkg::NODE_W];
    assign in_dep  = i_s_tdata[ddc_pkg::OP_W + ddc_pkg::NODE_W +: ddc_pkg::NODE_W];

    assign proj_ok = (32'(in_proj) < NODES);
    assign dep_ok  = (32'(in_dep) < NODES);

    assign uw        = ddc_pkg::ucode(r_step);
    assign in_accept = i_s_tvalid && uw.in_ready;

    // One spreading pass: a node becomes delayed if any node it depends on is.
    always_comb begin
        for (int p = 0; p < NODES; p++) begin
            spread[p] = r_mask[p] | (|(r_rows[p] & r_mask));
        end
    end

    // The scan moves on unless a delayed node waits for a free output register.
    assign scan_adv = !r_rem[0] || !r_m_tvalid || i_m_tready;

    // Sequencer: jump on the condition, otherwise hold the step.
    always_comb begin
        case (uw.cond)
            ddc_pkg::C_ALWAYS:  cond_met = 1'b1;
            ddc_pkg::C_COMPUTE: cond_met = in_accept && (in_op == ddc_pkg::OP_COMPUTE);
            ddc_pkg::C_STABLE:  cond_met = (spread == r_mask);
            ddc_pkg::C_EMPTY:   cond_met = (r_rem == '0);
            default:            cond_met = 1'b0;
        endcase
        n_step = cond_met ? uw.target : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ddc_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // Datapath, driven by the action field of the control word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NODES; p++) begin
                r_rows[p] <= '0;
            end
            r_mask <= '0;
        end else begin
            case (uw.act)
                ddc_pkg::A_LOAD: begin
                    if (in_accept && in_op == ddc_pkg::OP_EDGE && proj_ok && dep_ok) begin
                        r_rows[IDX_W'(in_proj)][IDX_W'(in_dep)] <= 1'b1;
                    end
                    if (in_accept && in_op == ddc_pkg::OP_MARK && proj_ok) begin
                        r_mask[IDX_W'(in_proj)] <= 1'b1;
                    end
                end
                ddc_pkg::A_PASS: begin
                    r_mask <= spread;
                end
                ddc_pkg::A_SCAN: begin
                    r_mask <= r_mask;
                end
                ddc_pkg::A_CLEAR: begin
                    for (int p = 0; p < NODES; p++) begin
                        r_rows[p] <= '0;
                    end
                    r_mask <= '0;
                end
                default: begin
                    r_mask <= r_mask;
                end
            endcase
        end
    end

    // Scan register and index: loaded on every pass step, so they hold the settled closure when the scan starts.
    always_ff @(posedge i_clk) begin
        if (uw.act == ddc_pkg::A_PASS) begin
            r_rem <= spread;
            r_idx <= '0;
        end else if (uw.act == ddc_pkg::A_SCAN && scan_adv) begin
            r_rem <= r_rem >> 1;
            r_idx <= r_idx + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (uw.act == ddc_pkg::A_SCAN && scan_adv && r_rem[0]) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.act == ddc_pkg::A_SCAN && scan_adv && r_rem[0]) begin
            r_m_node <= ddc_pkg::NODE_W'(r_idx);
            r_m_last <= (r_rem[NODES-1:1] == '0);
        end
    end

    assign o_s_tready = uw.in_ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(ddc_pkg::M_DATA_W - ddc_pkg::NODE_W){1'b0}}, r_m_node};
    assign o_m_tlast  = r_m_last;

endmodule
